>>> rtl/core/fnv1a_hashed_direct_table_top_macros.svh
// assertion macros shared by the hashed table modules
`ifndef FNV1A_HASHED_DIRECT_TABLE_TOP_MACROS_SVH
`define FNV1A_HASHED_DIRECT_TABLE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define FHT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define FHT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/fht_pkg.sv
// package: constants, op codes and the fnv-1a byte step for the hashed table
package fht_pkg;

   localparam int HASH_W = 32;
   localparam int VALUE_W = 32;
   localparam int KEY_BYTE_W = 8;
   localparam int OP_W = 2;
   localparam int SLOT_INDEX_W = 5;

   localparam int DEFAULT_TABLE_DEPTH = 32;

   localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_GET = 2'd2;
   localparam logic [OP_W-1:0] OP_UPDATE = 2'd3;

   // xor in the byte, then multiply by the fnv prime 0x01000193 as shift-add
   function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] hash,
                                                  input logic [KEY_BYTE_W-1:0] key_byte);
      logic [HASH_W-1:0] x;
      begin
         x = hash ^ {{(HASH_W-KEY_BYTE_W){1'b0}}, key_byte};
         return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
      end
   endfunction

endpackage

>>> rtl/core/fht_mod.sv
// remainder of a 32-bit hash by the table depth, by reciprocal multiply
`include "fnv1a_hashed_direct_table_top_macros.svh"

module fht_mod #(
   parameter int TABLE_DEPTH = fht_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic [fht_pkg::HASH_W-1:0]     dividend,
   output logic                           done,
   output logic [$clog2(TABLE_DEPTH)-1:0] rem
);

   localparam int RW = $clog2(TABLE_DEPTH);
   localparam int PW = 2 * fht_pkg::HASH_W;
   localparam logic [PW-1:0] MAGIC_WIDE =
      ((PW'(1) << fht_pkg::HASH_W) * ((PW'(1) << RW) - PW'(TABLE_DEPTH))) / PW'(TABLE_DEPTH)
      + PW'(1);
   localparam logic [fht_pkg::HASH_W-1:0] MAGIC = MAGIC_WIDE[fht_pkg::HASH_W-1:0];
   localparam logic [RW:0] DEPTH_W = (RW+1)'(TABLE_DEPTH);
   localparam logic [RW-1:0] DEPTH_LOW = RW'(TABLE_DEPTH);

   logic [fht_pkg::HASH_W-1:0] num_ff, num_in;
   logic [fht_pkg::HASH_W-1:0] hi_ff, hi_in;
   logic [RW-1:0]              quo_ff, quo_in;
   logic [RW-1:0]              rem_ff, rem_in;
   logic [2:0]                 stage_ff, stage_in;
   logic                       done_ff, done_in;
   logic [PW-1:0]              prod;
   logic [fht_pkg::HASH_W-1:0] sum;
   logic [RW-1:0]              qd;

   // high word of hash times magic, then quotient, then low bits of hash minus q*depth
   assign prod = PW'(num_ff) * PW'(MAGIC);
   assign sum = hi_ff + ((num_ff - hi_ff) >> 1);
   assign qd = quo_ff * DEPTH_LOW;

   always_comb begin
      num_in = num_ff;
      hi_in = hi_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      stage_in = {stage_ff[1:0], load};
      done_in = done_ff;
      if (stage_ff[0]) begin
         hi_in = prod[PW-1:fht_pkg::HASH_W];
      end
      if (stage_ff[1]) begin
         quo_in = RW'(sum >> (RW - 1));
      end
      if (stage_ff[2]) begin
         rem_in = num_ff[RW-1:0] - qd;
         done_in = 1'b1;
      end
      if (load) begin
         num_in = dividend;
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      hi_ff <= hi_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (reset) begin
         stage_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign rem = rem_ff;

   `FHT_ASSERT_IMPLY(a_rem_in_range, clock, reset, done_ff, (RW+1)'(rem_ff) < DEPTH_W, "remainder out of range")
   `FHT_ASSERT_IMPLY(a_stage_onehot, clock, reset, 1'b1, $onehot0(stage_ff), "overlapping remainder stages")
   `FHT_ASSERT_IMPLY(a_busy_done_excl, clock, reset, stage_ff != '0, !done_ff, "busy and done together")
   `FHT_ASSERT_NEXT(a_load_starts, clock, reset, load, stage_ff[0] && !done_ff, "load did not start")

endmodule

>>> rtl/core/fnv1a_hashed_direct_table_top.sv
// Key bytes stream in one per transaction and are folded into a running
// FNV-1a hash; while idle, a byte that is not the last of its key is taken
// every cycle. The last byte of a key occupies the block until its result is
// loaded: the remainder unit forms hash mod TABLE_DEPTH by reciprocal
// multiplication, the slot memory is read, and once the result register is
// free the slot is written as the op needs and the result loaded. After reset
// it clears the slot memory one entry per cycle, taking no transaction till then.
`include "fnv1a_hashed_direct_table_top_macros.svh"

module fnv1a_hashed_direct_table_top #(
   parameter int TABLE_DEPTH = fht_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [fht_pkg::KEY_BYTE_W-1:0]   req_key_byte,
   input  logic                             req_key_last,
   input  logic [fht_pkg::OP_W-1:0]         req_op,
   input  logic [fht_pkg::VALUE_W-1:0]      req_value_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fht_pkg::VALUE_W-1:0]      rsp_value_out,
   output logic [fht_pkg::SLOT_INDEX_W-1:0] rsp_slot_index,
   output logic                             rsp_status
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int MW = fht_pkg::VALUE_W + 1;
   localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_DEPTH - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_MOD = 3'd2;
   localparam logic [2:0] ST_EXEC = 3'd3;

   logic [2:0]                      state_ff, state_in;
   logic [IW-1:0]                   clr_addr_ff, clr_addr_in;
   logic [fht_pkg::HASH_W-1:0]      hash_ff, hash_in;
   logic [fht_pkg::HASH_W-1:0]      hash_next;
   logic [fht_pkg::OP_W-1:0]        op_ff;
   logic [fht_pkg::VALUE_W-1:0]     value_ff;
   logic [IW-1:0]                   slot_ff;
   logic [MW-1:0]                   slot_mem_ff [TABLE_DEPTH];
   logic [MW-1:0]                   rd_data_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [fht_pkg::VALUE_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [fht_pkg::SLOT_INDEX_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                            rsp_status_ff, rsp_status_in;

   logic          req_fire;
   logic          mod_load;
   logic          mod_done;
   logic [IW-1:0] mod_rem;
   logic          rd_en;
   logic          exec_fire;
   logic          occupied;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [MW-1:0] wr_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire = req_valid && req_ready;
   assign hash_next = fht_pkg::fnv_step(hash_ff, req_key_byte);
   assign mod_load = req_fire && req_key_last;

   fht_mod #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_mod (
      .clock   (clock),
      .reset   (reset),
      .load    (mod_load),
      .dividend(hash_next),
      .done    (mod_done),
      .rem     (mod_rem)
   );

   assign rd_en = (state_ff == ST_MOD) && mod_done;
   assign exec_fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign occupied = rd_data_ff[MW-1];

   always_comb begin
      state_in = state_ff;
      clr_addr_in = clr_addr_ff;
      hash_in = hash_ff;
      wr_en = 1'b0;
      wr_addr = slot_ff;
      wr_data = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_key_last) begin
                  hash_in = fht_pkg::FNV_BASIS;
                  state_in = ST_MOD;
               end else begin
                  hash_in = hash_next;
               end
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in = fht_pkg::SLOT_INDEX_W'(slot_ff);
               rsp_value_in = '0;
               rsp_status_in = 1'b0;
               case (op_ff)
                  fht_pkg::OP_INSERT: begin
                     if (occupied) begin
                        rsp_status_in = 1'b1;
                     end else begin
                        wr_en = 1'b1;
                        wr_data = {1'b1, value_ff};
                     end
                  end
                  fht_pkg::OP_REMOVE: begin
                     wr_en = 1'b1;
                  end
                  fht_pkg::OP_GET: begin
                     if (occupied) begin
                        rsp_value_in = rd_data_ff[fht_pkg::VALUE_W-1:0];
                     end
                  end
                  default: begin
                     wr_en = 1'b1;
                     wr_data = {1'b1, value_ff};
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[mod_rem];
      end
   end

   always_ff @(posedge clock) begin
      if (mod_load) begin
         op_ff <= req_op;
         value_ff <= req_value_in;
      end
      if (rd_en) begin
         slot_ff <= mod_rem;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_addr_ff <= '0;
         hash_ff <= fht_pkg::FNV_BASIS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_addr_ff <= clr_addr_in;
         hash_ff <= hash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_status = rsp_status_ff;

   `FHT_ASSERT_NEXT(a_hash_restart, clock, reset, mod_load, hash_ff == fht_pkg::FNV_BASIS, "hash not reset after last byte")
   `FHT_ASSERT_IMPLY(a_collide_zero, clock, reset, rsp_valid_ff && rsp_status_ff, rsp_value_ff == '0, "collision with nonzero value")
   `FHT_ASSERT_IMPLY(a_rsp_from_exec, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_EXEC, "result loaded outside execute")

endmodule
